// ===== design/lsbe_pkg.sv =====
// Shared types, constants and helper functions for the load-shift balance evaluator.
// Depends on nothing; lsbe_slot_unit and the top level refer to it by scoped names.

package lsbe_pkg;

    localparam int NUM_SLOTS = 24;

    // Field widths of the item channels
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int TBL_W    = 24;
    localparam int WATT_W   = 16;
    localparam int FACTOR_W = 4;
    localparam int OUT_W    = 32;

    localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    // Slot walk counter: holds start + runtime and the table depth itself
    localparam int CNT_W  = ($clog2(NUM_SLOTS + 1) > SLOT_W + 1) ?
                            $clog2(NUM_SLOTS + 1) : SLOT_W + 1;

    // Running balance, wide enough for two full walks of worst-case slots
    localparam int BAL_W = 36;

    // Per-slot contribution in tenths and its biased (always positive) form
    localparam int D_W      = TBL_W + 6;
    localparam int X_W      = D_W - 1;
    localparam int Q_W      = X_W - 3;
    localparam int RECIP_W  = 32;
    localparam int PROD_W   = X_W + RECIP_W;
    localparam int DIV_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
    // Bias of ten times 2^(Q_W-1) keeps the dividend positive; floor(x/10) is then offset
    localparam logic [Q_W-1:0] DIV_BIAS_Q = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [X_W-1:0] DIV_BIAS   = {DIV_BIAS_Q, 3'b000} + {2'b00, DIV_BIAS_Q, 1'b0};

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_EVAL  = 2'd2,
        KIND_APPLY = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [TBL_W-1:0]  value;
        logic [SLOT_W-1:0]        from_slot;
        logic [SLOT_W-1:0]        to_slot;
        logic [SLOT_W-1:0]        runtime;
        logic [WATT_W-1:0]        wattage;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  balance;
        logic                     positive;
        logic signed [TBL_W-1:0]  read_value;
    } res_t;

    // Control that travels with each table entry into the slot unit
    typedef struct packed {
        logic clear;
        logic vld;
        logic target;
    } slot_ctl_t;

    // One past the last covered slot, clipped at the table end
    function automatic logic [CNT_W-1:0] slot_end(input logic [SLOT_W-1:0] start,
                                                  input logic [SLOT_W-1:0] run);
        logic [CNT_W-1:0] sum;
        sum = CNT_W'(start) + CNT_W'(run);
        if (sum > CNT_W'(NUM_SLOTS))
            return CNT_W'(NUM_SLOTS);
        else
            return sum;
    endfunction

    function automatic logic signed [TBL_W-1:0] sat_tbl(input logic signed [TBL_W+1:0] v);
        logic signed [TBL_W+1:0] hi;
        logic signed [TBL_W+1:0] lo;
        hi = {3'b000, {(TBL_W-1){1'b1}}};
        lo = {3'b111, {(TBL_W-1){1'b0}}};
        if (v > hi)
            return hi[TBL_W-1:0];
        else if (v < lo)
            return lo[TBL_W-1:0];
        else
            return v[TBL_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [BAL_W-1:0] v);
        logic signed [BAL_W-1:0] hi;
        logic signed [BAL_W-1:0] lo;
        hi = {{(BAL_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        lo = {{(BAL_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
        if (v > hi)
            return hi[OUT_W-1:0];
        else if (v < lo)
            return lo[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

endpackage

// ===== design/lsbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.

module lsbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== design/lsbe_slot_unit.sv =====
// Pipelined slot scorer: one table entry per cycle, three stages
// (contribution in tenths, divide by ten, truncating accumulate).
// Depends on lsbe_pkg.

module lsbe_slot_unit (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  lsbe_pkg::slot_ctl_t                       ctl,
    input  logic signed [lsbe_pkg::TBL_W-1:0]         entry,
    input  logic [lsbe_pkg::WATT_W-1:0]               wattage,
    input  logic [lsbe_pkg::FACTOR_W-1:0]             factor,
    output logic                                      busy,
    output logic signed [lsbe_pkg::BAL_W-1:0]         balance
);

    localparam int D_W = lsbe_pkg::D_W;
    localparam int X_W = lsbe_pkg::X_W;
    localparam int Q_W = lsbe_pkg::Q_W;

    // stage 1: contribution d in tenths, biased positive
    logic signed [D_W-1:0]  a_x;
    logic signed [D_W-1:0]  neg_a;
    logic signed [D_W-1:0]  w_x;
    logic signed [D_W-1:0]  pen_x;
    logic signed [D_W-1:0]  d;
    logic [lsbe_pkg::WATT_W+lsbe_pkg::FACTOR_W-1:0] pen;
    logic [D_W:0]           x_sum;
    logic [X_W-1:0]         x_next;

    // stage 2: quotient by reciprocal
    logic [lsbe_pkg::PROD_W-1:0] prod;
    logic [Q_W-1:0]         q_next;

    // stage 3: floor remainder and truncating update
    logic [X_W-1:0]         ten_q;
    logic [X_W-1:0]         rem;
    logic signed [lsbe_pkg::BAL_W-1:0] s;
    logic signed [lsbe_pkg::BAL_W-1:0] bal_next;

    logic                   s1_vld_reg;
    logic [X_W-1:0]         x_reg;
    logic                   s2_vld_reg;
    logic [Q_W-1:0]         q_reg;
    logic [X_W-1:0]         x2_reg;
    logic signed [lsbe_pkg::BAL_W-1:0] bal_reg;

    always_comb
    begin
        a_x   = D_W'(entry);
        if (ctl.target)
            a_x = -a_x;
        neg_a = -a_x;
        pen   = factor * wattage;
        w_x   = D_W'(wattage);
        pen_x = D_W'(pen);
        priority if (a_x >= 0)
            d = -pen_x;
        else if (w_x <= neg_a)
            d = (w_x <<< 3) + (w_x <<< 1);
        else
            d = (neg_a <<< 4) + (neg_a <<< 2) - pen_x;
        x_sum  = {d[D_W-1], d} + (D_W+1)'(lsbe_pkg::DIV_BIAS);
        x_next = x_sum[X_W-1:0];
    end

    assign prod   = lsbe_pkg::PROD_W'(x_reg) * lsbe_pkg::PROD_W'(lsbe_pkg::DIV_RECIP);
    assign q_next = prod[lsbe_pkg::DIV_SHIFT +: Q_W];

    always_comb
    begin
        ten_q = (X_W'(q_reg) << 3) + (X_W'(q_reg) << 1);
        rem   = x2_reg - ten_q;
        s     = bal_reg + $signed(lsbe_pkg::BAL_W'(q_reg))
                - $signed(lsbe_pkg::BAL_W'(lsbe_pkg::DIV_BIAS_Q));
        // floor to truncation: a negative result with a remainder moves up by one
        if (s < 0 && rem[3:0] != 4'd0)
            bal_next = s + lsbe_pkg::BAL_W'(1);
        else
            bal_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            bal_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= ctl.vld;
            s2_vld_reg <= s1_vld_reg;
            if (ctl.clear)
                bal_reg <= '0;
            else if (s2_vld_reg)
                bal_reg <= bal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        q_reg  <= q_next;
        x2_reg <= x_reg;
    end

    assign busy    = s1_vld_reg | s2_vld_reg;
    assign balance = bal_reg;

endmodule

// ===== design/load_shift_balance_evaluator.sv =====
// Top level of the load-shift balance evaluator: item sequencer, adjustment table
// and slot scorer. Depends on lsbe_pkg, lsbe_ram and lsbe_slot_unit.
//
//   port group   | dir | handshake            | carries
//   cmd          | in  | cmd_valid/cmd_stall  | cmd_t: kind, slot, value, slots, runtime, wattage
//   res          | out | res_valid/res_stall  | res_t: balance, positive, read_value
//   cfg          | in  | cfg_we               | factor_tenths (4 bits)
//
// Write stores the value in an in-range slot. Read issues a table read, then captures it.
// Evaluate does one table read per covered slot, feeding the three-stage slot scorer.
// Apply does a read then a write per covered slot.
// Reset zeroes the table through per-slot valid bits; factor_tenths resets to 3.
// One item is in work at a time; cmd_stall is high until its result is registered.
// A held result does not block the next item, only the next result.

module load_shift_balance_evaluator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  lsbe_pkg::cmd_t                     cmd,
    output logic                               res_valid,
    input  logic                               res_stall,
    output lsbe_pkg::res_t                     res,
    input  logic                               cfg_we,
    input  logic [lsbe_pkg::FACTOR_W-1:0]      cfg_data
);

    localparam int CNT_W  = lsbe_pkg::CNT_W;
    localparam int ADDR_W = lsbe_pkg::ADDR_W;
    localparam int TBL_W  = lsbe_pkg::TBL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_READ_CAP,
        ST_EVAL,
        ST_DRAIN,
        ST_APPLY_RD,
        ST_APPLY_WR,
        ST_DONE
    } state_t;

    state_t                          state_reg,    state_next;
    lsbe_pkg::cmd_t                  cmd_reg,      cmd_next;
    logic                            phase_reg,    phase_next;
    logic [CNT_W-1:0]                idx_reg,      idx_next;
    logic [lsbe_pkg::NUM_SLOTS-1:0]  valid_reg,    valid_next;
    logic                            rd_vld_reg,   rd_vld_next;
    logic signed [TBL_W-1:0]         rd_value_reg, rd_value_next;
    lsbe_pkg::slot_ctl_t             ctl_reg,      ctl_next;
    lsbe_pkg::res_t                  res_reg,      res_next;
    logic                            res_valid_reg, res_valid_next;
    logic [lsbe_pkg::FACTOR_W-1:0]   factor_reg,   factor_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic signed [TBL_W-1:0] ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [TBL_W-1:0]        ram_rdata;
    logic signed [TBL_W-1:0] entry;

    logic [CNT_W-1:0]        end_cur;
    logic                    in_range;
    logic                    slot_ok;
    logic signed [TBL_W+1:0] apply_sum;
    logic                    unit_busy;
    logic signed [lsbe_pkg::BAL_W-1:0] unit_bal;

    lsbe_ram #(
        .WIDTH (TBL_W),
        .DEPTH (lsbe_pkg::NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lsbe_slot_unit u_slot (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .entry   (entry),
        .wattage (cmd_reg.wattage),
        .factor  (factor_reg),
        .busy    (unit_busy),
        .balance (unit_bal)
    );

    // never-written slots read as zero
    assign entry = rd_vld_reg ? $signed(ram_rdata) : '0;

    assign end_cur  = phase_reg ? lsbe_pkg::slot_end(cmd_reg.to_slot, cmd_reg.runtime)
                                : lsbe_pkg::slot_end(cmd_reg.from_slot, cmd_reg.runtime);
    assign in_range = idx_reg < end_cur;
    assign slot_ok  = CNT_W'(cmd_reg.slot) < CNT_W'(lsbe_pkg::NUM_SLOTS);

    always_comb
    begin
        if (phase_reg)
            apply_sum = (TBL_W+2)'(entry) - (TBL_W+2)'(cmd_reg.wattage);
        else
            apply_sum = (TBL_W+2)'(entry) + (TBL_W+2)'(cmd_reg.wattage);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        rd_value_next  = rd_value_reg;
        ctl_next       = '0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & res_stall;
        factor_next    = cfg_we ? cfg_data : factor_reg;

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(cmd.slot);
        ram_wdata = cmd.value;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    phase_next = 1'b0;
                    idx_next   = CNT_W'(cmd.from_slot);
                    unique case (cmd.kind)
                        lsbe_pkg::KIND_WRITE:
                        begin
                            if (CNT_W'(cmd.slot) < CNT_W'(lsbe_pkg::NUM_SLOTS))
                            begin
                                ram_we = 1'b1;
                                valid_next[ram_waddr] = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        lsbe_pkg::KIND_READ:
                            state_next = ST_READ;
                        lsbe_pkg::KIND_EVAL:
                        begin
                            ctl_next.clear = 1'b1;
                            state_next     = ST_EVAL;
                        end
                        lsbe_pkg::KIND_APPLY:
                            state_next = ST_APPLY_RD;
                    endcase
                end
            end
            ST_READ:
            begin
                ram_re     = slot_ok;
                ram_raddr  = ADDR_W'(cmd_reg.slot);
                state_next = ST_READ_CAP;
            end
            ST_READ_CAP:
            begin
                rd_value_next = entry;
                state_next    = ST_DONE;
            end
            ST_EVAL:
            begin
                priority if (in_range)
                begin
                    ram_re          = 1'b1;
                    ctl_next.vld    = 1'b1;
                    ctl_next.target = phase_reg;
                    idx_next        = idx_reg + CNT_W'(1);
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    idx_next   = CNT_W'(cmd_reg.to_slot);
                end
                else
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!ctl_reg.vld && !unit_busy)
                    state_next = ST_DONE;
            end
            ST_APPLY_RD:
            begin
                priority if (in_range)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_APPLY_WR;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    idx_next   = CNT_W'(cmd_reg.to_slot);
                end
                else
                    state_next = ST_DONE;
            end
            ST_APPLY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(idx_reg);
                ram_wdata = lsbe_pkg::sat_tbl(apply_sum);
                valid_next[ram_waddr] = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_APPLY_RD;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next = '0;
                    if (cmd_reg.kind == lsbe_pkg::KIND_EVAL)
                    begin
                        res_next.balance  = lsbe_pkg::sat_out(unit_bal);
                        res_next.positive = unit_bal > 0;
                    end
                    if (cmd_reg.kind == lsbe_pkg::KIND_READ)
                        res_next.read_value = rd_value_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase

        rd_vld_next = ram_re ? valid_reg[ram_raddr] : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rd_value_reg  <= '0;
            ctl_reg       <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
            factor_reg    <= lsbe_pkg::FACTOR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= rd_vld_next;
            rd_value_reg  <= rd_value_next;
            ctl_reg       <= ctl_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
            factor_reg    <= factor_next;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_unit_only_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        unit_busy |-> (state_reg == ST_EVAL || state_reg == ST_DRAIN))
        else $error("slot unit busy outside evaluate");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) < CNT_W'(lsbe_pkg::NUM_SLOTS)))
        else $error("table write beyond last slot");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> res_valid_reg)
        else $error("finished item left no result");

endmodule
